// ----- rtl/core/ras_pkg.sv -----
// package: shared types, codes and widths for the rational arithmetic unit
`timescale 1ns / 1ps
package ras_pkg;
	localparam int unsigned OpW = 16;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DEN_ZERO = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic signed [OpW-1:0] a_num;
		logic signed [OpW-1:0] a_den;
		logic signed [OpW-1:0] b_num;
		logic signed [OpW-1:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] raw_num;
		logic [30:0]        raw_den;
		logic [30:0]        whole_part;
		logic signed [31:0] red_num;
		logic [30:0]        red_den;
		logic [1:0]         status;
	} rsp_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_GCD1_INIT,
		DP_DIV_STEP,
		DP_GCD_SWAP,
		DP_LCM_INIT,
		DP_SCALE_A_INIT,
		DP_SCALE_B_INIT,
		DP_COMBINE,
		DP_WHOLE_INIT,
		DP_WHOLE_DONE,
		DP_GCD2_INIT,
		DP_RDEN_INIT,
		DP_RNUM_INIT,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic   err_den;
		logic   err_div;
		logic   addsub;
		logic   den_zero;
		logic   gcd_b_zero;
	} dp_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_GCD1_INIT,
		S_GCD1_DIV,
		S_GCD1_SWAP,
		S_LCM,
		S_SCALE_A,
		S_SCALE_B,
		S_COMBINE,
		S_WHOLE,
		S_GCD2,
		S_RDEN,
		S_RNUM,
		S_FINISH,
		S_DONE
	} state_t;
endpackage

// ----- rtl/core/ras_datapath.sv -----
// datapath: operand registers, multipliers, shared restoring divider
`timescale 1ns / 1ps
module ras_datapath
	import ras_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_op_t                op,
	input  logic signed [OpW-1:0] in_a_num,
	input  logic signed [OpW-1:0] in_a_den,
	input  logic signed [OpW-1:0] in_b_num,
	input  logic signed [OpW-1:0] in_b_den,
	input  logic [1:0]            in_mode,
	output dp_status_t            stat,
	output logic                  div_last,
	output rsp_t                  rsp
);
	localparam int unsigned DW = 64;
	localparam int unsigned CW = $clog2(DW);
	// sign-moved operands and the scale factors fit one bit above the operand width
	localparam int unsigned MW = OpW + 1;

	logic [DW-1:0] an_q, ad_q, bn_q, bd_q, num_q, den_q, x_q, y_q, t_q;
	logic [DW-1:0] quo_q, rem_q, dvd_q, dvs_q, whole_q, mag_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    mode_q;
	logic          err_den_q, err_div_q, rneg_q;
	logic [DW:0]   trial;
	logic [DW-1:0] rem_sh;
	logic [DW-1:0] ea_n, ea_d, eb_n, eb_d, adp, bdp, anp, bnp;
	logic [DW-1:0] prod_sa, prod_sb;
	logic signed [2*MW-1:0] p_nn, p_dd, p_nd, p_dn, p_sa, p_sb, p_lcm;

	assign ea_n = DW'(in_a_num);
	assign ea_d = DW'(in_a_den);
	assign eb_n = DW'(in_b_num);
	assign eb_d = DW'(in_b_den);
	assign adp = ea_d[DW-1] ? -ea_d : ea_d;
	assign anp = ea_d[DW-1] ? -ea_n : ea_n;
	assign bdp = eb_d[DW-1] ? -eb_d : eb_d;
	assign bnp = eb_d[DW-1] ? -eb_n : eb_n;

	assign rem_sh = {rem_q[DW-2:0], dvd_q[DW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};
	assign div_last = (cnt_q == '1);

	// narrow signed products, sign-extended to the datapath width
	assign p_nn  = $signed(anp[MW-1:0]) * $signed(bnp[MW-1:0]);
	assign p_dd  = $signed(adp[MW-1:0]) * $signed(bdp[MW-1:0]);
	assign p_nd  = $signed(anp[MW-1:0]) * $signed(bdp[MW-1:0]);
	assign p_dn  = $signed(adp[MW-1:0]) * $signed(bnp[MW-1:0]);
	assign p_sa  = $signed(an_q[MW-1:0]) * $signed(quo_q[MW-1:0]);
	assign p_sb  = $signed(bn_q[MW-1:0]) * $signed(quo_q[MW-1:0]);
	assign p_lcm = $signed(quo_q[MW-1:0]) * $signed(bd_q[MW-1:0]);

	// scaled numerators, combinational; num_q registers them where they are used
	assign prod_sa = DW'(p_sa);
	assign prod_sb = DW'(p_sb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op == DP_DIV_STEP) begin
			cnt_q <= cnt_q + 1'b1;
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			DP_LOAD: begin
				mode_q    <= in_mode;
				err_den_q <= (ea_d == '0) || (eb_d == '0);
				err_div_q <= (in_mode == MODE_DIV) && (bnp == '0);
				an_q <= anp; ad_q <= adp; bn_q <= bnp; bd_q <= bdp;
				x_q <= adp; y_q <= bdp;
				if (in_mode == MODE_DIV) begin
					// negative divisor numerator: move the sign back up
					num_q <= bnp[DW-1] ? -DW'(p_nd) : DW'(p_nd);
					den_q <= bnp[DW-1] ? -DW'(p_dn) : DW'(p_dn);
				end else begin
					num_q <= DW'(p_nn);
					den_q <= DW'(p_dd);
				end
			end
			DP_GCD1_INIT, DP_GCD2_INIT: begin
				dvd_q <= x_q; dvs_q <= y_q; rem_q <= '0; quo_q <= '0;
			end
			DP_DIV_STEP: begin
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
				if (!trial[DW]) begin
					rem_q <= trial[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end
			DP_GCD_SWAP: begin
				x_q <= y_q; y_q <= rem_q;
			end
			DP_LCM_INIT: begin
				// lcm = (ad / g) * bd, g in x_q
				dvd_q <= ad_q; dvs_q <= x_q; rem_q <= '0; quo_q <= '0;
			end
			DP_SCALE_A_INIT: begin
				den_q <= DW'(p_lcm);
				t_q <= '0;
			end
			DP_SCALE_B_INIT: begin
				if (t_q == '0) begin
					dvd_q <= den_q; dvs_q <= ad_q; rem_q <= '0; quo_q <= '0;
					t_q <= '1;
				end else begin
					num_q <= prod_sa;
					dvd_q <= den_q; dvs_q <= bd_q; rem_q <= '0; quo_q <= '0;
				end
			end
			DP_COMBINE: begin
				num_q <= (mode_q == MODE_ADD) ? num_q + prod_sb : num_q - prod_sb;
			end
			DP_WHOLE_INIT: begin
				whole_q <= '0;
				mag_q <= num_q;
				dvd_q <= num_q; dvs_q <= den_q; rem_q <= '0; quo_q <= '0;
			end
			DP_WHOLE_DONE: begin
				if (!num_q[DW-1] && num_q >= den_q) begin
					whole_q <= quo_q;
					mag_q   <= rem_q;
				end
				rneg_q <= mag_q[DW-1] && !(!num_q[DW-1] && num_q >= den_q);
				x_q <= (mag_q[DW-1] && !(!num_q[DW-1] && num_q >= den_q)) ?
					-mag_q : ((!num_q[DW-1] && num_q >= den_q) ? rem_q : mag_q);
				y_q <= den_q;
			end
			DP_RDEN_INIT: begin
				// gcd in x_q; den /= g first
				t_q <= x_q;
				dvd_q <= den_q; dvs_q <= x_q; rem_q <= '0; quo_q <= '0;
			end
			DP_RNUM_INIT: begin
				den_q <= quo_q;
				dvd_q <= rneg_q ? -mag_q : mag_q; dvs_q <= t_q;
				rem_q <= '0; quo_q <= '0;
			end
			DP_FINISH: begin
				mag_q <= rneg_q ? -quo_q : quo_q;
			end
			default: ;
		endcase
	end

	assign stat.err_den    = err_den_q;
	assign stat.err_div    = err_div_q;
	assign stat.addsub     = !mode_q[1];
	assign stat.den_zero   = (den_q == '0);
	assign stat.gcd_b_zero = (y_q == '0);

	logic [DW-1:0] raw_num_q, raw_den_q;
	always_ff @(posedge clk) begin
		if (op == DP_WHOLE_INIT) begin
			raw_num_q <= num_q;
			raw_den_q <= den_q;
		end
	end

	always_comb begin
		rsp = '0;
		if (err_den_q) begin
			rsp.status = ST_DEN_ZERO;
		end else if (err_div_q) begin
			rsp.status = ST_DIV_ZERO;
		end else begin
			rsp.raw_num    = raw_num_q[31:0];
			rsp.raw_den    = raw_den_q[30:0];
			rsp.whole_part = whole_q[30:0];
			rsp.red_num    = (raw_den_q == '0) ? raw_num_q[31:0] : mag_q[31:0];
			rsp.red_den    = (raw_den_q == '0) ? raw_den_q[30:0] : den_q[30:0];
			rsp.status     = ST_OK;
		end
	end
endmodule

// ----- rtl/core/ras_ctrl.sv -----
// controller: sequences loads, gcd loops and divisions
`timescale 1ns / 1ps
module ras_ctrl
	import ras_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t stat,
	input  logic       div_last,
	output dp_op_t     op,
	output logic       busy,
	output logic       done
);
	state_t state_q, state_d, ret_q, ret_d;
	logic   phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			phase_q <= phase_d;
		end
	end

	// S_GCD1_DIV is the shared 64-step divider; ret_q says where to go after
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		phase_d = phase_q;
		op      = DP_NOP;
		busy    = (state_q != S_IDLE);
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op = DP_LOAD;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (stat.err_den || stat.err_div) begin
					state_d = S_DONE;
				end else if (stat.addsub) begin
					state_d = S_GCD1_INIT;
				end else begin
					state_d = S_WHOLE;
					phase_d = 1'b0;
				end
			end
			S_GCD1_INIT: begin
				if (stat.gcd_b_zero) begin
					op = DP_LCM_INIT;
					ret_d = S_LCM;
				end else begin
					op = DP_GCD1_INIT;
					ret_d = S_GCD1_SWAP;
				end
				state_d = S_GCD1_DIV;
			end
			S_GCD1_DIV: begin
				op = DP_DIV_STEP;
				if (div_last) state_d = ret_q;
			end
			S_GCD1_SWAP: begin
				op = DP_GCD_SWAP;
				state_d = S_GCD1_INIT;
			end
			S_LCM: begin
				op = DP_SCALE_A_INIT;
				state_d = S_SCALE_A;
			end
			S_SCALE_A: begin
				op = DP_SCALE_B_INIT;
				ret_d = S_SCALE_B;
				state_d = S_GCD1_DIV;
			end
			S_SCALE_B: begin
				op = DP_SCALE_B_INIT;
				ret_d = S_COMBINE;
				state_d = S_GCD1_DIV;
			end
			S_COMBINE: begin
				op = DP_COMBINE;
				state_d = S_WHOLE;
				phase_d = 1'b0;
			end
			S_WHOLE: begin
				if (!phase_q) begin
					if (stat.den_zero) begin
						op = DP_WHOLE_INIT;
						state_d = S_DONE;
					end else begin
						op = DP_WHOLE_INIT;
						phase_d = 1'b1;
						ret_d = S_WHOLE;
						state_d = S_GCD1_DIV;
					end
				end else begin
					op = DP_WHOLE_DONE;
					state_d = S_GCD2;
				end
			end
			S_GCD2: begin
				if (stat.gcd_b_zero) begin
					op = DP_RDEN_INIT;
					ret_d = S_RDEN;
				end else begin
					op = DP_GCD2_INIT;
					ret_d = S_RNUM;
				end
				state_d = S_GCD1_DIV;
			end
			S_RNUM: begin
				op = DP_GCD_SWAP;
				state_d = S_GCD2;
			end
			S_RDEN: begin
				op = DP_RNUM_INIT;
				ret_d = S_FINISH;
				state_d = S_GCD1_DIV;
			end
			S_FINISH: begin
				// sign goes back on the reduced numerator before the strobe
				op = DP_FINISH;
				state_d = S_DONE;
			end
			S_DONE: begin
				phase_d = 1'b0;
				state_d = S_IDLE;
				done = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- rtl/core/rational_arith_simplify_unit.sv -----
// top level: rational arithmetic with gcd reduction and whole-part split
//
//  channel | signals                 | meaning
//  --------+-------------------------+--------------------------------------
//  request | start, busy, req        | taken when start high and busy low
//  result  | done, rsp               | valid for exactly one cycle on done
//
// every gcd step, the lcm, both scalings, the whole-part split and the
// reduction run through one 64-step shift and subtract divider; a euclid step
// runs an init, the divider steps and a swap
// a zero denominator or zero divisor goes from the load state straight to done
// one request at a time: busy stays high from acceptance through done
// reset clears the controller and the divider step counter; the other datapath registers are loaded on use
// the receiver cannot stall, done is a single-cycle strobe
`timescale 1ns / 1ps
module rational_arith_simplify_unit
	import ras_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);
	dp_op_t     op;
	dp_status_t stat;
	logic       div_last;
	rsp_t       rsp_d;

	ras_ctrl u_ctrl (
		.clk, .arst_n, .start, .stat, .div_last, .op, .busy, .done
	);

	// the final sign fix-up runs the cycle before done, so the datapath
	// registers already hold the full response during the strobe
	ras_datapath u_dp (
		.clk, .arst_n, .op,
		.in_a_num(req.a_num),
		.in_a_den(req.a_den),
		.in_b_num(req.b_num),
		.in_b_den(req.b_den),
		.in_mode(req.mode),
		.stat, .div_last, .rsp(rsp_d)
	);

	assign rsp = rsp_d;
endmodule
